@@ design/sha256_pkg.sv @@
// Shared types, constants and round functions of the SHA-256 stream hasher.
package sha256_pkg;

    localparam int BLOCK_BYTES  = 64;
    localparam int NUM_ROUNDS   = 64;
    localparam int DIGEST_WORDS = 8;

    localparam logic [5:0] BLOCK_LAST  = 6'(BLOCK_BYTES - 1);
    localparam logic [5:0] ROUND_LAST  = 6'(NUM_ROUNDS - 1);
    localparam logic [2:0] DIGEST_LAST = 3'(DIGEST_WORDS - 1);
    localparam logic [5:0] LENGTH_AT   = 6'd56;
    localparam logic [7:0] PAD_MARK    = 8'h80;

    typedef logic [31:0] word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_ADD,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic       push;
        logic [7:0] data;
        logic       step;
        logic       expand;
    } sched_ctrl_t;

    typedef struct packed {
        logic       load;
        logic       round;
        logic       add;
        logic       rotate;
        logic       init;
        logic [5:0] idx;
    } core_ctrl_t;

    function automatic word_t rotr(input word_t x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic word_t big_sigma0(input word_t x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic word_t small_sigma0(input word_t x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic word_t choose(input word_t e, input word_t f, input word_t g);
        return (e & f) ^ (~e & g);
    endfunction

    function automatic word_t majority(input word_t a, input word_t b, input word_t c);
        return (a & b) ^ (a & c) ^ (b & c);
    endfunction

    function automatic word_t iv_word(input logic [2:0] i);
        word_t v;
        case (i)
            3'd0:    v = 32'h6A09E667;
            3'd1:    v = 32'hBB67AE85;
            3'd2:    v = 32'h3C6EF372;
            3'd3:    v = 32'hA54FF53A;
            3'd4:    v = 32'h510E527F;
            3'd5:    v = 32'h9B05688C;
            3'd6:    v = 32'h1F83D9AB;
            3'd7:    v = 32'h5BE0CD19;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic word_t round_k(input logic [5:0] r);
        word_t k;
        case (r)
            6'd0:  k = 32'h428A2F98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hB5C0FBCF;  6'd3:  k = 32'hE9B5DBA5;
            6'd4:  k = 32'h3956C25B;  6'd5:  k = 32'h59F111F1;
            6'd6:  k = 32'h923F82A4;  6'd7:  k = 32'hAB1C5ED5;
            6'd8:  k = 32'hD807AA98;  6'd9:  k = 32'h12835B01;
            6'd10: k = 32'h243185BE;  6'd11: k = 32'h550C7DC3;
            6'd12: k = 32'h72BE5D74;  6'd13: k = 32'h80DEB1FE;
            6'd14: k = 32'h9BDC06A7;  6'd15: k = 32'hC19BF174;
            6'd16: k = 32'hE49B69C1;  6'd17: k = 32'hEFBE4786;
            6'd18: k = 32'h0FC19DC6;  6'd19: k = 32'h240CA1CC;
            6'd20: k = 32'h2DE92C6F;  6'd21: k = 32'h4A7484AA;
            6'd22: k = 32'h5CB0A9DC;  6'd23: k = 32'h76F988DA;
            6'd24: k = 32'h983E5152;  6'd25: k = 32'hA831C66D;
            6'd26: k = 32'hB00327C8;  6'd27: k = 32'hBF597FC7;
            6'd28: k = 32'hC6E00BF3;  6'd29: k = 32'hD5A79147;
            6'd30: k = 32'h06CA6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27B70A85;  6'd33: k = 32'h2E1B2138;
            6'd34: k = 32'h4D2C6DFC;  6'd35: k = 32'h53380D13;
            6'd36: k = 32'h650A7354;  6'd37: k = 32'h766A0ABB;
            6'd38: k = 32'h81C2C92E;  6'd39: k = 32'h92722C85;
            6'd40: k = 32'hA2BFE8A1;  6'd41: k = 32'hA81A664B;
            6'd42: k = 32'hC24B8B70;  6'd43: k = 32'hC76C51A3;
            6'd44: k = 32'hD192E819;  6'd45: k = 32'hD6990624;
            6'd46: k = 32'hF40E3585;  6'd47: k = 32'h106AA070;
            6'd48: k = 32'h19A4C116;  6'd49: k = 32'h1E376C08;
            6'd50: k = 32'h2748774C;  6'd51: k = 32'h34B0BCB5;
            6'd52: k = 32'h391C0CB3;  6'd53: k = 32'h4ED8AA4A;
            6'd54: k = 32'h5B9CCA4F;  6'd55: k = 32'h682E6FF3;
            6'd56: k = 32'h748F82EE;  6'd57: k = 32'h78A5636F;
            6'd58: k = 32'h84C87814;  6'd59: k = 32'h8CC70208;
            6'd60: k = 32'h90BEFFFA;  6'd61: k = 32'hA4506CEB;
            6'd62: k = 32'hBEF9A3F7;  6'd63: k = 32'hC67178F2;
            default: k = '0;
        endcase
        return k;
    endfunction

endpackage

@@ design/sha256_if.sv @@
// Handshake interfaces for the message byte channel and the digest word channel.
interface sha256_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       message_end;

    modport source (
        output valid,
        output data_byte,
        output byte_valid,
        output message_end,
        input  ready
    );

    modport sink (
        input  valid,
        input  data_byte,
        input  byte_valid,
        input  message_end,
        output ready
    );
endinterface

interface sha256_word_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (
        output valid,
        output digest_word,
        output word_index,
        output last_word,
        input  ready
    );

    modport sink (
        input  valid,
        input  digest_word,
        input  word_index,
        input  last_word,
        output ready
    );
endinterface

@@ design/sha256_sched.sv @@
// Block buffer and message schedule window as one 512-bit shift line.
module sha256_sched (
    input  logic                      clk,
    input  sha256_pkg::sched_ctrl_t   ctrl,
    output sha256_pkg::word_t         w
);
    import sha256_pkg::*;

    logic [511:0] win_reg;
    logic [511:0] win_next;
    word_t        tap0;
    word_t        tap1;
    word_t        tap9;
    word_t        tap14;
    word_t        w_new;

    // The oldest word sits at the top; loaded bytes enter at the bottom.
    assign tap0  = win_reg[511:480];
    assign tap1  = win_reg[479:448];
    assign tap9  = win_reg[223:192];
    assign tap14 = win_reg[63:32];

    always_comb
    begin
        if (ctrl.expand)
        begin
            w_new = small_sigma1(tap14) + tap9 + small_sigma0(tap1) + tap0;
        end
        else
        begin
            w_new = tap0;
        end
    end

    assign w = w_new;

    always_comb
    begin
        win_next = win_reg;
        if (ctrl.push)
        begin
            win_next = {win_reg[503:0], ctrl.data};
        end
        else if (ctrl.step)
        begin
            win_next = {win_reg[479:0], w_new};
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

endmodule

@@ design/sha256_core.sv @@
// Compression round unit with working variables and the chaining hash ring.
module sha256_core (
    input  logic                    clk,
    input  logic                    rst_n,
    input  sha256_pkg::core_ctrl_t  ctrl,
    input  sha256_pkg::word_t       w,
    output sha256_pkg::word_t       digest_word
);
    import sha256_pkg::*;

    word_t hash_reg  [DIGEST_WORDS];
    word_t hash_next [DIGEST_WORDS];
    word_t work_reg  [DIGEST_WORDS];
    word_t work_next [DIGEST_WORDS];
    word_t t1;
    word_t t2;

    assign t1 = work_reg[7] + big_sigma1(work_reg[4])
              + choose(work_reg[4], work_reg[5], work_reg[6]) + round_k(ctrl.idx) + w;
    assign t2 = big_sigma0(work_reg[0]) + majority(work_reg[0], work_reg[1], work_reg[2]);

    always_comb
    begin
        work_next = work_reg;
        hash_next = hash_reg;
        if (ctrl.load)
        begin
            work_next = hash_reg;
        end
        else if (ctrl.round)
        begin
            work_next[7] = work_reg[6];
            work_next[6] = work_reg[5];
            work_next[5] = work_reg[4];
            work_next[4] = work_reg[3] + t1;
            work_next[3] = work_reg[2];
            work_next[2] = work_reg[1];
            work_next[1] = work_reg[0];
            work_next[0] = t1 + t2;
        end
        else if (ctrl.add)
        begin
            // One feed-forward add per cycle; both rings turn so word 0 is next.
            for (int i = 0; i < DIGEST_WORDS - 1; i++)
            begin
                hash_next[i] = hash_reg[i + 1];
                work_next[i] = work_reg[i + 1];
            end
            hash_next[DIGEST_WORDS - 1] = hash_reg[0] + work_reg[0];
            work_next[DIGEST_WORDS - 1] = work_reg[0];
        end

        if (ctrl.init)
        begin
            for (int i = 0; i < DIGEST_WORDS; i++)
            begin
                hash_next[i] = iv_word(3'(i));
            end
        end
        else if (ctrl.rotate)
        begin
            for (int i = 0; i < DIGEST_WORDS - 1; i++)
            begin
                hash_next[i] = hash_reg[i + 1];
            end
            hash_next[DIGEST_WORDS - 1] = hash_reg[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIGEST_WORDS; i++)
            begin
                hash_reg[i] <= iv_word(3'(i));
            end
        end
        else
        begin
            hash_reg <= hash_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
    end

    assign digest_word = hash_reg[0];

endmodule

@@ design/sha256_stream_hasher.sv @@
// Streaming SHA-256 hasher: byte input, eight digest words out per message.
// Each accepted word on msg may carry one message byte and may end the message. The
// byte path takes one byte per cycle while idle; the 64th byte of a block starts the
// compression, which runs one round per cycle on a single round unit and then folds
// the eight working words into the hash. At message end the padding bytes are shifted
// in one per cycle (up to 64 per block, plus a second compression when the length does
// not fit), then the eight digest words are offered on digest, most significant first,
// one per cycle while digest.ready is high. msg.ready is low from a block's completion
// until the last digest word (or the compression) is done.
module sha256_stream_hasher (
    input  logic                clk,
    input  logic                rst_n,
    sha256_byte_if.sink         msg,
    sha256_word_if.source       digest
);
    import sha256_pkg::*;

    state_t       state_reg;
    state_t       state_next;
    logic [5:0]   fill_reg;
    logic [5:0]   fill_next;
    logic [63:0]  bits_reg;
    logic [63:0]  bits_next;
    logic [5:0]   cnt_reg;
    logic [5:0]   cnt_next;
    logic         ending_reg;
    logic         ending_next;
    logic         mark_reg;
    logic         mark_next;
    logic         last_reg;
    logic         last_next;
    sched_ctrl_t  sctl;
    core_ctrl_t   cctl;
    word_t        sched_w;
    word_t        hash_top;

    sha256_sched u_sched (
        .clk  (clk),
        .ctrl (sctl),
        .w    (sched_w)
    );

    sha256_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (cctl),
        .w           (sched_w),
        .digest_word (hash_top)
    );

    assign digest.digest_word = hash_top;
    assign digest.word_index  = cnt_reg[2:0];
    assign digest.last_word   = (cnt_reg[2:0] == DIGEST_LAST);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            fill_reg   <= '0;
            bits_reg   <= '0;
            cnt_reg    <= '0;
            ending_reg <= 1'b0;
            mark_reg   <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            bits_reg   <= bits_next;
            cnt_reg    <= cnt_next;
            ending_reg <= ending_next;
            mark_reg   <= mark_next;
            last_reg   <= last_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        bits_next    = bits_reg;
        cnt_next     = cnt_reg;
        ending_next  = ending_reg;
        mark_next    = mark_reg;
        last_next    = last_reg;
        sctl         = '0;
        cctl         = '0;
        cctl.idx     = cnt_reg;
        msg.ready    = 1'b0;
        digest.valid = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                msg.ready = 1'b1;
                if (msg.valid)
                begin
                    if (msg.byte_valid)
                    begin
                        sctl.push = 1'b1;
                        sctl.data = msg.data_byte;
                        bits_next = bits_reg + 64'd8;
                        fill_next = fill_reg + 6'd1;
                    end
                    if (msg.message_end)
                    begin
                        ending_next = 1'b1;
                        mark_next   = 1'b0;
                        last_next   = 1'b0;
                    end
                    if (msg.byte_valid && (fill_reg == BLOCK_LAST))
                    begin
                        state_next = ST_ROUND;
                        cctl.load  = 1'b1;
                        cnt_next   = '0;
                    end
                    else if (msg.message_end)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end

            ST_PAD:
            begin
                sctl.push = 1'b1;
                fill_next = fill_reg + 6'd1;
                if (!mark_reg)
                begin
                    sctl.data = PAD_MARK;
                    mark_next = 1'b1;
                    // The length fits behind the mark only if the mark lands before it.
                    last_next = (fill_reg < LENGTH_AT);
                end
                else if (last_reg && (fill_reg >= LENGTH_AT))
                begin
                    sctl.data = bits_reg[{~fill_reg[2:0], 3'b000} +: 8];
                end
                else
                begin
                    sctl.data = 8'h00;
                end
                if (fill_reg == BLOCK_LAST)
                begin
                    state_next = ST_ROUND;
                    cctl.load  = 1'b1;
                    cnt_next   = '0;
                end
            end

            ST_ROUND:
            begin
                sctl.step   = 1'b1;
                sctl.expand = (cnt_reg[5:4] != 2'b00);
                cctl.round  = 1'b1;
                cnt_next    = cnt_reg + 6'd1;
                if (cnt_reg == ROUND_LAST)
                begin
                    state_next = ST_ADD;
                    cnt_next   = '0;
                end
            end

            ST_ADD:
            begin
                cctl.add = 1'b1;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg[2:0] == DIGEST_LAST)
                begin
                    cnt_next = '0;
                    if (!ending_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (mark_reg && last_reg)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        // A full block that held the mark leaves the length for the next one.
                        state_next = ST_PAD;
                        if (mark_reg)
                        begin
                            last_next = 1'b1;
                        end
                    end
                end
            end

            ST_EMIT:
            begin
                digest.valid = 1'b1;
                if (digest.ready)
                begin
                    cctl.rotate = 1'b1;
                    cnt_next    = cnt_reg + 6'd1;
                    if (cnt_reg[2:0] == DIGEST_LAST)
                    begin
                        cctl.init   = 1'b1;
                        cnt_next    = '0;
                        bits_next   = '0;
                        fill_next   = '0;
                        ending_next = 1'b0;
                        mark_next   = 1'b0;
                        last_next   = 1'b0;
                        state_next  = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        msg.ready |-> !digest.valid)
        else $error("byte channel ready while a digest word is offered");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) |-> (fill_reg == 6'd0))
        else $error("compression running on a partly filled block");

    assert property (@(posedge clk) disable iff (!rst_n)
        digest.valid |-> (ending_reg && mark_reg && last_reg && (fill_reg == 6'd0)))
        else $error("digest offered before padding and length were absorbed");

    assert property (@(posedge clk) disable iff (!rst_n)
        (digest.valid && digest.ready && digest.last_word) |=> (msg.ready && (bits_reg == 64'd0)))
        else $error("hasher not returned to a fresh message after the last word");
`endif

endmodule
